@@ src/spd_pkg.sv @@
// Shared types and constants for the sensor packet deframer.
package spd_pkg;

    localparam logic [7:0] MARK_FIRST  = 8'hEF;
    localparam logic [7:0] MARK_SECOND = 8'h01;
    localparam logic [7:0] TYPE_DATA   = 8'h02;
    localparam logic [7:0] TYPE_END    = 8'h08;

    localparam logic [3:0] HDR_FIRST_IDX = 4'd2;
    localparam logic [3:0] HDR_TYPE_IDX  = 4'd6;
    localparam logic [3:0] HDR_LENH_IDX  = 4'd7;
    localparam logic [3:0] HDR_LENL_IDX  = 4'd8;
    localparam logic [3:0] HDR_BYTES     = 4'd9;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DATA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DATA = 2'd1;

    localparam logic [15:0] MAX_DATA_RESET = 16'd16384;
    localparam logic [15:0] MIN_DATA_RESET = 16'd256;

    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_RESTART = 2'd1;
    localparam logic [1:0] ACT_EOS     = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_MARK2,
        PH_HEADER,
        PH_BODY,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_RECEIVING,
        ST_SUCCESS,
        ST_OVER_LIMIT,
        ST_TOO_SMALL,
        ST_NO_END
    } status_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        packet_last;
        status_t     status;
        logic [15:0] total_bytes;
    } result_t;

    typedef struct packed {
        logic [15:0] max_data_bytes;
        logic [15:0] min_data_bytes;
    } limits_t;

endpackage

@@ src/spd_item_if.sv @@
// Request channel carrying one action and received byte.
interface spd_item_if;
    logic          valid;
    logic          ready;
    spd_pkg::item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ src/spd_result_if.sv @@
// Request channel carrying one deframer result.
interface spd_result_if;
    logic             valid;
    logic             ready;
    spd_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ src/spd_cfg_if.sv @@
// Register write channel: index and data.
interface spd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [spd_pkg::CFG_IDX_W-1:0]   index;
    logic [15:0]                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/spd_core.sv @@
// Deframer state registers and per-byte next-state logic.
module spd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  spd_pkg::item_t   item,
    input  spd_pkg::limits_t limits,
    output spd_pkg::result_t result
);

    spd_pkg::phase_t  phase_reg, phase_next;
    logic [3:0]       hdr_idx_reg, hdr_idx_next;
    logic [7:0]       type_reg, type_next;
    logic [15:0]      len_reg, len_next;
    logic [15:0]      body_cnt_reg, body_cnt_next;
    logic [15:0]      total_reg, total_next;
    spd_pkg::status_t status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= spd_pkg::PH_HUNT;
            hdr_idx_reg  <= '0;
            type_reg     <= '0;
            len_reg      <= '0;
            body_cnt_reg <= '0;
            total_reg    <= '0;
            status_reg   <= spd_pkg::ST_RECEIVING;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            hdr_idx_reg  <= hdr_idx_next;
            type_reg     <= type_next;
            len_reg      <= len_next;
            body_cnt_reg <= body_cnt_next;
            total_reg    <= total_next;
            status_reg   <= status_next;
        end
    end

    always_comb
    begin
        logic        carries;
        logic [15:0] dl;
        logic [16:0] sum;
        logic [3:0]  idx_inc;
        logic [15:0] cnt_inc;
        logic        last;

        phase_next    = phase_reg;
        hdr_idx_next  = hdr_idx_reg;
        type_next     = type_reg;
        len_next      = len_reg;
        body_cnt_next = body_cnt_reg;
        total_next    = total_reg;
        status_next   = status_reg;
        result        = '0;
        carries       = 1'b0;
        dl            = '0;
        sum           = '0;
        idx_inc       = hdr_idx_reg + 4'd1;
        cnt_inc       = body_cnt_reg + 16'd1;
        last          = 1'b0;

        if (item.action == spd_pkg::ACT_RESTART)
        begin
            phase_next    = spd_pkg::PH_HUNT;
            hdr_idx_next  = '0;
            type_next     = '0;
            len_next      = '0;
            body_cnt_next = '0;
            total_next    = '0;
            status_next   = spd_pkg::ST_RECEIVING;
        end
        else if (item.action == spd_pkg::ACT_EOS)
        begin
            if (status_reg == spd_pkg::ST_RECEIVING)
            begin
                status_next = spd_pkg::ST_NO_END;
                phase_next  = spd_pkg::PH_DONE;
            end
        end
        else if (item.action == spd_pkg::ACT_BYTE && status_reg == spd_pkg::ST_RECEIVING)
        begin
            unique case (phase_reg)
                spd_pkg::PH_HUNT:
                begin
                    if (item.rx_byte == spd_pkg::MARK_FIRST)
                        phase_next = spd_pkg::PH_MARK2;
                end
                spd_pkg::PH_MARK2:
                begin
                    if (item.rx_byte == spd_pkg::MARK_SECOND)
                    begin
                        phase_next   = spd_pkg::PH_HEADER;
                        hdr_idx_next = spd_pkg::HDR_FIRST_IDX;
                    end
                    else if (item.rx_byte != spd_pkg::MARK_FIRST)
                        phase_next = spd_pkg::PH_HUNT;
                end
                spd_pkg::PH_HEADER:
                begin
                    if (hdr_idx_reg == spd_pkg::HDR_TYPE_IDX)
                        type_next = item.rx_byte;
                    else if (hdr_idx_reg == spd_pkg::HDR_LENH_IDX)
                        len_next = {item.rx_byte, 8'h00};
                    else if (hdr_idx_reg == spd_pkg::HDR_LENL_IDX)
                        len_next = {len_reg[15:8], item.rx_byte};
                    hdr_idx_next = idx_inc;
                    if (idx_inc >= spd_pkg::HDR_BYTES)
                    begin
                        // end of header: decide how the body is handled
                        hdr_idx_next  = '0;
                        body_cnt_next = '0;
                        carries = (type_next == spd_pkg::TYPE_DATA) ||
                                  (type_next == spd_pkg::TYPE_END);
                        dl  = (len_next < 16'd2) ? 16'd0 : len_next - 16'd2;
                        sum = {1'b0, total_reg} + {1'b0, dl};
                        if (carries && sum > {1'b0, limits.max_data_bytes})
                        begin
                            status_next = spd_pkg::ST_OVER_LIMIT;
                            phase_next  = spd_pkg::PH_DONE;
                        end
                        else if (carries && dl == 16'd0 && type_next == spd_pkg::TYPE_END)
                        begin
                            status_next = (total_reg < limits.min_data_bytes) ?
                                          spd_pkg::ST_TOO_SMALL : spd_pkg::ST_SUCCESS;
                            phase_next  = spd_pkg::PH_DONE;
                        end
                        else
                            phase_next = (len_next == 16'd0) ? spd_pkg::PH_HUNT
                                                             : spd_pkg::PH_BODY;
                    end
                end
                spd_pkg::PH_BODY:
                begin
                    carries = (type_reg == spd_pkg::TYPE_DATA) ||
                              (type_reg == spd_pkg::TYPE_END);
                    dl = (len_reg < 16'd2) ? 16'd0 : len_reg - 16'd2;
                    if (carries && body_cnt_reg < dl)
                    begin
                        last               = (cnt_inc == dl);
                        result.data_byte   = item.rx_byte;
                        result.data_valid  = 1'b1;
                        result.packet_last = last;
                        if (total_reg != 16'hFFFF)
                            total_next = total_reg + 16'd1;
                    end
                    if (last && type_reg == spd_pkg::TYPE_END)
                    begin
                        status_next = (total_next < limits.min_data_bytes) ?
                                      spd_pkg::ST_TOO_SMALL : spd_pkg::ST_SUCCESS;
                        phase_next  = spd_pkg::PH_DONE;
                    end
                    else
                    begin
                        body_cnt_next = cnt_inc;
                        if (cnt_inc >= len_reg)
                            phase_next = spd_pkg::PH_HUNT;
                    end
                end
                default:
                begin
                end
            endcase
        end

        result.status      = status_next;
        result.total_bytes = total_next;
    end

endmodule

@@ src/sensor_packet_deframer.sv @@
// Top level of the sensor packet deframer: handshakes, limits, result register.
//
// Usage: bytes from the sensor link enter on the item channel, one request per
// byte, together with an action code (byte, restart capture, end of stream).
// Every accepted request yields exactly one request on the result channel:
// the extracted payload byte if any, a last-of-packet flag, the capture
// status after that request, and the running payload total.
// The cfg channel writes the two limits (index 0 maximum total, index 1
// minimum total); it is always ready and takes effect on the next byte.
// A request accepted at an edge shows its result at the output register after
// that edge. Throughput is one request per cycle while the receiver does not
// stall, set by the single state update between the input handshake and the
// output register. While the receiver stalls with a result waiting, item.ready
// drops and the state holds; it rises again in the cycle the result is taken.
// Reset clears the capture state, sets the limits to 16384 and 256 and
// empties the result register.
module sensor_packet_deframer (
    input  logic  clk,
    input  logic  rst_n,
    spd_item_if.sink     item,
    spd_result_if.source result,
    spd_cfg_if.sink      cfg
);

    spd_pkg::limits_t limits_reg;
    spd_pkg::result_t core_res;
    spd_pkg::result_t res_reg;
    logic             res_valid_reg;
    logic             accept;

    assign item.ready = !res_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.max_data_bytes <= spd_pkg::MAX_DATA_RESET;
            limits_reg.min_data_bytes <= spd_pkg::MIN_DATA_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == spd_pkg::REG_MAX_DATA)
                limits_reg.max_data_bytes <= cfg.data;
            else if (cfg.index == spd_pkg::REG_MIN_DATA)
                limits_reg.min_data_bytes <= cfg.data;
        end
    end

    spd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item.payload),
        .limits (limits_reg),
        .result (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= core_res;
    end

    assign result.valid   = res_valid_reg;
    assign result.payload = res_reg;

    a_no_data_after_fail: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.payload.data_valid |->
            result.payload.status != spd_pkg::ST_OVER_LIMIT &&
            result.payload.status != spd_pkg::ST_NO_END)
        else $error("payload byte with failed status");

    a_last_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.payload.packet_last |-> result.payload.data_valid)
        else $error("packet_last without data");

    a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.payload.data_valid |-> result.payload.data_byte == 8'h00)
        else $error("data_byte nonzero without data");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.payload.action == spd_pkg::ACT_RESTART |=>
            result.valid && result.payload.status == spd_pkg::ST_RECEIVING &&
            result.payload.total_bytes == 16'd0)
        else $error("restart did not clear capture");

endmodule

@@ test/sensor_packet_deframer_test.sv @@
// Self-checking testbench for the sensor packet deframer: random packet streams, limits, stalls.
module sensor_packet_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 40;
    localparam int unsigned HOLD_AFTER = 400;

    class capture_tracker;
        logic [15:0]      max_bytes;
        logic [15:0]      min_bytes;
        spd_pkg::phase_t  phase;
        logic [3:0]       hdr_idx;
        logic [7:0]       pkt_type;
        logic [15:0]      pkt_len;
        logic [15:0]      body_cnt;
        logic [15:0]      total;
        spd_pkg::status_t status;
        spd_pkg::result_t frame_outputs[$];
        int unsigned      mismatches;

        function new();
            max_bytes = spd_pkg::MAX_DATA_RESET;
            min_bytes = spd_pkg::MIN_DATA_RESET;
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            phase = spd_pkg::PH_HUNT;
            hdr_idx = '0;
            pkt_type = '0;
            pkt_len = '0;
            body_cnt = '0;
            total = '0;
            status = spd_pkg::ST_RECEIVING;
        endfunction

        function void set_limit(logic [spd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
            if (idx == spd_pkg::REG_MAX_DATA)
                max_bytes = value;
            else if (idx == spd_pkg::REG_MIN_DATA)
                min_bytes = value;
        endfunction

        function bit carries_data();
            return pkt_type == spd_pkg::TYPE_DATA || pkt_type == spd_pkg::TYPE_END;
        endfunction

        function logic [15:0] payload_len();
            return (pkt_len < 16'd2) ? 16'd0 : pkt_len - 16'd2;
        endfunction

        function void complete_capture();
            status = (total < min_bytes) ? spd_pkg::ST_TOO_SMALL : spd_pkg::ST_SUCCESS;
            phase = spd_pkg::PH_DONE;
        endfunction

        function int pending();
            return frame_outputs.size();
        endfunction

        function void absorb_request(spd_pkg::item_t req);
            spd_pkg::result_t res;
            logic [15:0]      plen;
            logic [16:0]      sum;
            bit               ended;
            res = '0;
            ended = 1'b0;
            if (req.action == spd_pkg::ACT_RESTART)
            begin
                clear();
            end
            else if (req.action == spd_pkg::ACT_EOS)
            begin
                if (status == spd_pkg::ST_RECEIVING)
                begin
                    status = spd_pkg::ST_NO_END;
                    phase = spd_pkg::PH_DONE;
                end
            end
            else if (req.action == spd_pkg::ACT_BYTE && status == spd_pkg::ST_RECEIVING)
            begin
                case (phase)
                    spd_pkg::PH_HUNT:
                    begin
                        if (req.rx_byte == spd_pkg::MARK_FIRST)
                            phase = spd_pkg::PH_MARK2;
                    end
                    spd_pkg::PH_MARK2:
                    begin
                        if (req.rx_byte == spd_pkg::MARK_SECOND)
                        begin
                            phase = spd_pkg::PH_HEADER;
                            hdr_idx = spd_pkg::HDR_FIRST_IDX;
                        end
                        else if (req.rx_byte != spd_pkg::MARK_FIRST)
                        begin
                            phase = spd_pkg::PH_HUNT;
                        end
                    end
                    spd_pkg::PH_HEADER:
                    begin
                        if (hdr_idx == spd_pkg::HDR_TYPE_IDX)
                            pkt_type = req.rx_byte;
                        else if (hdr_idx == spd_pkg::HDR_LENH_IDX)
                            pkt_len = {req.rx_byte, 8'h00};
                        else if (hdr_idx == spd_pkg::HDR_LENL_IDX)
                            pkt_len[7:0] = req.rx_byte;
                        hdr_idx = hdr_idx + 4'd1;
                        if (hdr_idx >= spd_pkg::HDR_BYTES)
                        begin
                            hdr_idx = '0;
                            body_cnt = '0;
                            sum = {1'b0, total} + {1'b0, payload_len()};
                            if (carries_data() && sum > {1'b0, max_bytes})
                            begin
                                status = spd_pkg::ST_OVER_LIMIT;
                                phase = spd_pkg::PH_DONE;
                            end
                            else if (carries_data() && payload_len() == 16'd0
                                     && pkt_type == spd_pkg::TYPE_END)
                            begin
                                complete_capture();
                            end
                            else
                            begin
                                phase = (pkt_len == 16'd0) ? spd_pkg::PH_HUNT
                                                           : spd_pkg::PH_BODY;
                            end
                        end
                    end
                    spd_pkg::PH_BODY:
                    begin
                        plen = payload_len();
                        if (carries_data() && body_cnt < plen)
                        begin
                            res.data_byte = req.rx_byte;
                            res.data_valid = 1'b1;
                            res.packet_last = (body_cnt + 16'd1 == plen);
                            if (total != 16'hFFFF)
                                total = total + 16'd1;
                            if (res.packet_last && pkt_type == spd_pkg::TYPE_END)
                            begin
                                complete_capture();
                                ended = 1'b1;
                            end
                        end
                        if (!ended)
                        begin
                            body_cnt = body_cnt + 16'd1;
                            if (body_cnt >= pkt_len)
                                phase = spd_pkg::PH_HUNT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            res.status = status;
            res.total_bytes = total;
            frame_outputs.push_back(res);
        endfunction

        function void check_output(spd_pkg::result_t got);
            spd_pkg::result_t want;
            if (frame_outputs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: byte %h valid %b last %b status %0d total %0d",
                             got.data_byte, got.data_valid, got.packet_last, got.status,
                             got.total_bytes);
                return;
            end
            want = frame_outputs.pop_front();
            if (got.data_byte !== want.data_byte || got.data_valid !== want.data_valid
                || got.packet_last !== want.packet_last || got.status !== want.status
                || got.total_bytes !== want.total_bytes)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch exp/act: byte %h/%h valid %b/%b last %b/%b",
                              " status %0d/%0d total %0d/%0d"},
                             want.data_byte, got.data_byte, want.data_valid, got.data_valid,
                             want.packet_last, got.packet_last, want.status, got.status,
                             want.total_bytes, got.total_bytes);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic hold_off = 1'b0;
    bit   gaps_on = 1'b1;
    int   live_items = 0;
    int unsigned cycle_count = 0;

    capture_tracker sb = new();

    spd_item_if   item_ch();
    spd_result_if result_ch();
    spd_cfg_if    cfg_ch();

    sensor_packet_deframer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic send_item(input logic [1:0] action, input logic [7:0] value);
        spd_pkg::item_t req;
        req.action = action;
        req.rx_byte = value;
        if (action != ACT_UNUSED && (sb.status == spd_pkg::ST_RECEIVING
                                     || action == spd_pkg::ACT_RESTART))
            live_items++;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.payload <= req;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.absorb_request(req);
    endtask

    task automatic send_packet(input logic [7:0] kind, input logic [15:0] len, input int body_n);
        send_item(spd_pkg::ACT_BYTE, spd_pkg::MARK_FIRST);
        send_item(spd_pkg::ACT_BYTE, spd_pkg::MARK_SECOND);
        repeat (4) send_item(spd_pkg::ACT_BYTE, 8'($urandom));
        send_item(spd_pkg::ACT_BYTE, kind);
        send_item(spd_pkg::ACT_BYTE, len[15:8]);
        send_item(spd_pkg::ACT_BYTE, len[7:0]);
        repeat (body_n) send_item(spd_pkg::ACT_BYTE, 8'($urandom));
    endtask

    task automatic write_limit(input logic [spd_pkg::CFG_IDX_W-1:0] idx,
                               input logic [15:0] value);
        item_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.set_limit(idx, value);
    endtask

    task automatic run_random(input int n);
        int          target;
        int          r;
        int          body_n;
        logic [7:0]  kind;
        logic [15:0] len;
        target = live_items + n;
        while (live_items < target)
        begin
            if (sb.status != spd_pkg::ST_RECEIVING && $urandom_range(0, 4) != 0)
                send_item(spd_pkg::ACT_RESTART, 8'($urandom));
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                r = $urandom_range(0, 99);
                kind = (r < 45) ? spd_pkg::TYPE_DATA
                     : (r < 75) ? spd_pkg::TYPE_END : 8'($urandom);
                r = $urandom_range(0, 99);
                if (r < 85)
                begin
                    len = 16'($urandom_range(0, 24));
                    body_n = len;
                end
                else if (r < 92)
                begin
                    len = 16'($urandom_range(25, 120));
                    body_n = len;
                end
                else
                begin
                    // huge length: header only plus a few body bytes, then cut off
                    len = 16'($urandom);
                    body_n = $urandom_range(0, 12);
                    if (body_n > len)
                        body_n = len;
                end
                if ($urandom_range(0, 9) == 0)
                    body_n = $urandom_range(0, body_n);
                send_packet(kind, len, body_n);
                if (body_n < len)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_item(spd_pkg::ACT_RESTART, 8'($urandom));
                    else
                        send_item(spd_pkg::ACT_EOS, 8'($urandom));
                end
            end
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(spd_pkg::ACT_BYTE, ($urandom_range(0, 3) == 0) ?
                              spd_pkg::MARK_FIRST : 8'($urandom));
            end
            else if (r < 88)
            begin
                send_item(spd_pkg::ACT_RESTART, 8'($urandom));
            end
            else if (r < 94)
            begin
                send_item(spd_pkg::ACT_EOS, 8'($urandom));
            end
            else
            begin
                send_item(ACT_UNUSED, 8'($urandom));
            end
        end
    endtask

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_output(result_ch.payload);
            if (stall_left > 0)
                stall_left--;
            else if (gaps_on && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 3);
            result_ch.ready <= (stall_left == 0) && !hold_off;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin : receiver_hold
        wait (live_items >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // mark hunting, data packet with extreme bytes, unused action, end of stream
        send_item(spd_pkg::ACT_BYTE, 8'h00);
        send_item(spd_pkg::ACT_BYTE, spd_pkg::MARK_FIRST);
        send_item(spd_pkg::ACT_BYTE, spd_pkg::MARK_FIRST);
        send_item(spd_pkg::ACT_BYTE, spd_pkg::MARK_SECOND);
        send_item(spd_pkg::ACT_BYTE, 8'hFF);
        send_item(spd_pkg::ACT_BYTE, 8'h00);
        send_item(spd_pkg::ACT_BYTE, 8'hA5);
        send_item(spd_pkg::ACT_BYTE, 8'h5A);
        send_item(spd_pkg::ACT_BYTE, spd_pkg::TYPE_DATA);
        send_item(spd_pkg::ACT_BYTE, 8'h00);
        send_item(spd_pkg::ACT_BYTE, 8'h04);
        send_item(spd_pkg::ACT_BYTE, 8'hFF);
        send_item(spd_pkg::ACT_BYTE, 8'h00);
        send_item(spd_pkg::ACT_BYTE, 8'h12);
        send_item(spd_pkg::ACT_BYTE, 8'h34);
        send_item(ACT_UNUSED, 8'hFF);
        send_item(spd_pkg::ACT_EOS, 8'h00);
        send_item(spd_pkg::ACT_BYTE, spd_pkg::MARK_FIRST);
        send_item(spd_pkg::ACT_RESTART, 8'h00);
        // end packet with short length: no payload, finishes under minimum
        send_packet(spd_pkg::TYPE_END, 16'h0001, 0);
        send_item(spd_pkg::ACT_RESTART, 8'hFF);
        // over limit at reset maximum
        send_packet(spd_pkg::TYPE_DATA, 16'hFFFF, 0);
        send_item(spd_pkg::ACT_RESTART, 8'h00);

        run_random(150);

        write_limit(spd_pkg::REG_MAX_DATA, 16'd0);
        write_limit(spd_pkg::REG_MIN_DATA, 16'd0);
        run_random(100);

        write_limit(spd_pkg::REG_MAX_DATA, 16'hFFFF);
        write_limit(spd_pkg::REG_MIN_DATA, 16'hFFFF);
        run_random(100);

        repeat (5)
        begin
            write_limit(spd_pkg::REG_MAX_DATA, 16'($urandom_range(20, 300)));
            write_limit(spd_pkg::REG_MIN_DATA, 16'($urandom_range(0, 120)));
            run_random(120);
        end

        gaps_on = 1'b0;
        write_limit(spd_pkg::REG_MAX_DATA, spd_pkg::MAX_DATA_RESET);
        write_limit(spd_pkg::REG_MIN_DATA, 16'($urandom_range(0, 60)));
        run_random(100);

        item_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/spd_pkg.sv
src/spd_item_if.sv
src/spd_result_if.sv
src/spd_cfg_if.sv
src/spd_core.sv
src/sensor_packet_deframer.sv
test/sensor_packet_deframer_test.sv
